[rtl/core/ttcpu_pkg.sv]
package ttcpu_pkg;

    localparam logic [3:0] REQ_SYS_EXIT      = 4'd0;
    localparam logic [3:0] REQ_IRQ_ENTRY     = 4'd1;
    localparam logic [3:0] REQ_IRQ_EXIT      = 4'd2;
    localparam logic [3:0] REQ_SOFTIRQ_ENTRY = 4'd3;
    localparam logic [3:0] REQ_SOFTIRQ_EXIT  = 4'd4;
    localparam logic [3:0] REQ_SOFTIRQ_RAISE = 4'd5;
    localparam logic [3:0] REQ_SWITCH        = 4'd6;
    localparam logic [3:0] REQ_FORK          = 4'd7;
    localparam logic [3:0] REQ_FREE          = 4'd8;
    localparam logic [3:0] REQ_STATEDUMP     = 4'd9;
    localparam logic [3:0] REQ_WAKEUP        = 4'd10;
    localparam logic [3:0] REQ_SYS_ENTRY     = 4'd11;

    localparam logic [3:0] ST_UNSET       = 4'd0;
    localparam logic [3:0] ST_IDLE        = 4'd1;
    localparam logic [3:0] ST_USER        = 4'd2;
    localparam logic [3:0] ST_SYSCALL     = 4'd3;
    localparam logic [3:0] ST_IRQ         = 4'd4;
    localparam logic [3:0] ST_SOFTIRQ     = 4'd5;
    localparam logic [3:0] ST_UNKNOWN     = 4'd6;
    localparam logic [3:0] ST_BLOCKED     = 4'd7;
    localparam logic [3:0] ST_INTERRUPTED = 4'd8;
    localparam logic [3:0] ST_WAIT_CPU    = 4'd9;

    localparam logic [7:0] DUMP_WAIT_CPU = 8'd2;
    localparam logic [7:0] DUMP_BLOCKED  = 8'd5;

    localparam int THREAD_ENTRY_W = 31;

    typedef struct packed {
        logic [3:0]  req_type;
        logic [2:0]  cpu_id;
        logic [15:0] thread_id;
        logic [15:0] other_thread_id;
        logic        prev_runnable;
        logic [7:0]  dump_status;
        logic [7:0]  irq_number;
        logic [3:0]  softirq_vector;
        logic [9:0]  syscall_id;
    } in_pkt_t;

    typedef struct packed {
        logic [3:0]  cpu_status;
        logic [3:0]  thread_status;
        logic        thread_touched;
        logic [15:0] thread_out;
        logic        tid_out_of_range;
    } out_pkt_t;

    typedef struct packed {
        logic [3:0]  state;
        logic [9:0]  syscall;
        logic        parent_valid;
        logic [15:0] parent;
    } thread_entry_t;

endpackage

[rtl/core/trace_thread_cpu_state_tracker_unit.sv]
// Channel  | Handshake            | Payload
// input    | in_valid, in_stall   | in_data  (ttcpu_pkg::in_pkt_t)
// output   | out_valid, out_stall | out_data (ttcpu_pkg::out_pkt_t)
// config   | cfg_we               | cfg_data (clone syscall id)
// Each event passes through these steps in order: accept, read of the first thread entry, read of the second
// thread entry with write-back of the first, and final write-back into the output register.
// The single-write-port thread memory sets this sequence.
// After reset a clearing pass writes every thread entry before the
// first transfer is accepted. A stalled output holds the last step until the register frees.
module trace_thread_cpu_state_tracker_unit #(
    parameter int NUM_CPUS    = 8,
    parameter int NUM_THREADS = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  ttcpu_pkg::in_pkt_t in_data,
    output logic               out_valid,
    input  logic               out_stall,
    output ttcpu_pkg::out_pkt_t out_data,
    input  logic               cfg_we,
    input  logic [9:0]         cfg_data
);
    import ttcpu_pkg::*;

    localparam int TW = $clog2(NUM_THREADS);
    localparam int CW = (NUM_CPUS > 1) ? $clog2(NUM_CPUS) : 1;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RDA   = 3'd2;
    localparam logic [2:0] S_RDB   = 3'd3;
    localparam logic [2:0] S_WB    = 3'd4;

    logic [2:0]    state_reg, state_next;
    logic [TW:0]   clr_reg;
    logic [9:0]    clone_reg;
    in_pkt_t       item_reg;
    logic          cvalid_reg [NUM_CPUS];
    logic [15:0]   cthread_reg [NUM_CPUS];
    logic [3:0]    cstate_reg [NUM_CPUS];
    thread_entry_t a_q_reg;
    logic          a_wr_reg;
    thread_entry_t a_wdata_reg;
    logic          out_valid_reg;
    out_pkt_t      out_reg;

    logic          ram_we;
    logic [TW-1:0] ram_waddr, ram_raddr;
    thread_entry_t ram_wdata, ram_q;
    logic [THREAD_ENTRY_W-1:0] ram_q_raw;

    logic [5:0]    cpu_x;
    logic [CW-1:0] ci;
    logic          cpu_ok, has_cur, cur_ok, rep_valid, b_ok, tid_ok_t, tid_ok_o;
    logic [15:0]   cur, a_tid, b_tid;
    logic          a_wr;
    thread_entry_t a_new, b_old, b_new;
    logic          b_wr, ncpu_v, oor, wb_go;
    logic [3:0]    ncpu, s24;
    logic [9:0]    ps;
    out_pkt_t      res;

    assign cpu_x    = 6'(item_reg.cpu_id);
    assign ci       = cpu_x[CW-1:0];
    assign cpu_ok   = 7'(cpu_x) < 7'(NUM_CPUS);
    assign has_cur  = cpu_ok && cvalid_reg[ci];
    assign cur      = has_cur ? cthread_reg[ci] : 16'd0;
    assign cur_ok   = has_cur && (17'(cur) < 17'(NUM_THREADS));
    assign tid_ok_t = 17'(item_reg.thread_id) < 17'(NUM_THREADS);
    assign tid_ok_o = 17'(item_reg.other_thread_id) < 17'(NUM_THREADS);
    assign a_tid    = (item_reg.req_type == REQ_SWITCH) ? item_reg.thread_id
                                                        : item_reg.other_thread_id;
    assign wb_go    = !out_valid_reg || !out_stall;

    always_comb
    begin
        rep_valid = has_cur;
        b_tid     = cur;
        case (item_reg.req_type) inside
            REQ_SWITCH:
            begin
                rep_valid = 1'b1;
                b_tid     = item_reg.other_thread_id;
            end
            REQ_FORK, REQ_FREE, REQ_STATEDUMP, REQ_WAKEUP:
            begin
                rep_valid = 1'b1;
                b_tid     = item_reg.thread_id;
            end
            default:
            begin
                rep_valid = has_cur;
                b_tid     = cur;
            end
        endcase
        b_ok = rep_valid && (17'(b_tid) < 17'(NUM_THREADS));
    end

    always_comb
    begin
        a_new       = ram_q;
        a_new.state = item_reg.prev_runnable ? ST_WAIT_CPU : ST_BLOCKED;
        a_wr        = (item_reg.req_type == REQ_SWITCH) && tid_ok_t;
    end

    assign b_old = (a_wr_reg && (a_tid == b_tid)) ? a_wdata_reg : ram_q;

    always_comb
    begin
        b_new  = b_old;
        b_wr   = 1'b0;
        ncpu_v = 1'b0;
        ncpu   = ST_UNSET;
        oor    = 1'b0;
        s24    = (cur_ok && b_old.syscall != 10'd0) ? ST_SYSCALL : ST_USER;
        ps     = tid_ok_o ? a_q_reg.syscall : 10'd0;
        case (item_reg.req_type) inside
            REQ_SYS_EXIT:
            begin
                b_wr          = cur_ok;
                b_new.syscall = 10'd0;
                b_new.state   = ST_USER;
                ncpu_v        = 1'b1;
                ncpu          = ST_USER;
                oor           = has_cur && !cur_ok;
            end
            REQ_IRQ_ENTRY, REQ_SOFTIRQ_ENTRY:
            begin
                b_wr        = cur_ok;
                b_new.state = ST_INTERRUPTED;
                ncpu_v      = 1'b1;
                ncpu        = (item_reg.req_type == REQ_IRQ_ENTRY) ? ST_IRQ : ST_SOFTIRQ;
                oor         = has_cur && !cur_ok;
            end
            REQ_IRQ_EXIT, REQ_SOFTIRQ_EXIT:
            begin
                b_wr        = cur_ok;
                b_new.state = s24;
                ncpu_v      = 1'b1;
                ncpu        = (!has_cur || cur == 16'd0) ? ST_IDLE : s24;
                oor         = has_cur && !cur_ok;
            end
            REQ_SWITCH:
            begin
                b_wr        = tid_ok_o;
                b_new.state = (tid_ok_o && b_old.syscall != 10'd0) ? ST_SYSCALL : ST_USER;
                ncpu_v      = 1'b1;
                ncpu        = (item_reg.other_thread_id == 16'd0) ? ST_IDLE : b_new.state;
                oor         = !tid_ok_t || !tid_ok_o;
            end
            REQ_FORK:
            begin
                b_wr               = tid_ok_t;
                b_new.parent_valid = 1'b1;
                b_new.parent       = item_reg.other_thread_id;
                b_new.state        = ST_WAIT_CPU;
                b_new.syscall      = (ps != 10'd0) ? ps : clone_reg;
                oor                = !tid_ok_t || !tid_ok_o;
            end
            REQ_FREE:
            begin
                b_wr  = tid_ok_t;
                b_new = '0;
                oor   = !tid_ok_t;
            end
            REQ_STATEDUMP:
            begin
                if (!b_old.parent_valid)
                begin
                    b_new.parent_valid = 1'b1;
                    b_new.parent       = item_reg.other_thread_id;
                    b_wr               = tid_ok_t;
                end
                if (b_old.state == ST_UNSET)
                begin
                    b_new.state = (item_reg.dump_status == DUMP_WAIT_CPU) ? ST_WAIT_CPU :
                                  (item_reg.dump_status == DUMP_BLOCKED) ? ST_BLOCKED :
                                  ST_UNKNOWN;
                    b_wr        = tid_ok_t;
                end
                oor = !tid_ok_t;
            end
            REQ_WAKEUP:
            begin
                if (b_old.state != ST_USER && b_old.state != ST_SYSCALL)
                begin
                    b_new.state = ST_WAIT_CPU;
                    b_wr        = tid_ok_t;
                end
                oor = !tid_ok_t;
            end
            REQ_SYS_ENTRY:
            begin
                b_wr          = cur_ok;
                b_new.syscall = item_reg.syscall_id;
                b_new.state   = ST_SYSCALL;
                ncpu_v        = 1'b1;
                ncpu          = ST_SYSCALL;
                oor           = has_cur && !cur_ok;
            end
            default:
            begin
                b_wr = 1'b0;
            end
        endcase
        res.cpu_status       = !cpu_ok ? ST_UNSET : (ncpu_v ? ncpu : cstate_reg[ci]);
        res.thread_status    = b_ok ? (b_wr ? b_new.state : b_old.state) : ST_UNSET;
        res.thread_touched   = b_wr || a_wr_reg;
        res.thread_out       = rep_valid ? b_tid : 16'd0;
        res.tid_out_of_range = oor;
    end

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = b_tid[TW-1:0];
        ram_wdata = b_new;
        ram_raddr = a_tid[TW-1:0];
        state_next = state_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg[TW-1:0];
                ram_wdata = '0;
                if (clr_reg == (TW + 1)'(NUM_THREADS - 1))
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_RDA;
                end
            end
            S_RDA:
            begin
                state_next = S_RDB;
            end
            S_RDB:
            begin
                ram_raddr  = b_tid[TW-1:0];
                ram_we     = a_wr;
                ram_waddr  = a_tid[TW-1:0];
                ram_wdata  = a_new;
                state_next = S_WB;
            end
            S_WB:
            begin
                ram_raddr = b_tid[TW-1:0];
                if (wb_go)
                begin
                    ram_we     = b_wr;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign ram_q = thread_entry_t'(ram_q_raw);

    ttcpu_ram #(
        .WIDTH (THREAD_ENTRY_W),
        .DEPTH (NUM_THREADS)
    ) u_thread_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_q_raw)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            clone_reg     <= 10'd1;
            out_valid_reg <= 1'b0;
            a_wr_reg      <= 1'b0;
            for (int i = 0; i < NUM_CPUS; i++)
            begin
                cvalid_reg[i]  <= 1'b0;
                cthread_reg[i] <= '0;
                cstate_reg[i]  <= ST_UNSET;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_CLEAR)
            begin
                clr_reg <= clr_reg + 1'b1;
            end
            if (cfg_we)
            begin
                clone_reg <= cfg_data;
            end
            if (state_reg == S_RDB)
            begin
                a_wr_reg <= a_wr;
            end
            if (state_reg == S_WB && wb_go)
            begin
                out_valid_reg <= 1'b1;
                if (cpu_ok && ncpu_v)
                begin
                    cstate_reg[ci] <= ncpu;
                end
                if (cpu_ok && item_reg.req_type == REQ_SWITCH)
                begin
                    cvalid_reg[ci]  <= 1'b1;
                    cthread_reg[ci] <= item_reg.other_thread_id;
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_valid)
        begin
            item_reg <= in_data;
        end
        if (state_reg == S_RDB)
        begin
            a_q_reg     <= ram_q;
            a_wdata_reg <= a_new;
        end
        if (state_reg == S_WB && wb_go)
        begin
            out_reg <= res;
        end
    end

    assign in_stall  = state_reg != S_IDLE;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    a_accept_starts : assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> state_reg == S_RDA)
        else $error("accepted transfer did not start a lookup");

    a_idle_no_write : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_IDLE |-> !ram_we)
        else $error("thread memory written while idle");

    a_wb_delivers : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_WB && wb_go |=> out_valid && state_reg == S_IDLE)
        else $error("write-back did not produce a result");

    a_clear_blocks : assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> in_stall && !out_valid)
        else $error("transfer possible during clearing pass");

endmodule

[rtl/core/ttcpu_ram.sv]
module ttcpu_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[bench/tb_checker.sv]
`timescale 1ns / 100ps

module tb_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_stall,
    input  ttcpu_pkg::in_pkt_t  in_data,
    input  logic                out_valid,
    input  logic                out_stall,
    input  ttcpu_pkg::out_pkt_t out_data,
    input  logic                cfg_we,
    input  logic [9:0]          cfg_data,
    output int                  errors,
    output int                  pending
);
    import ttcpu_pkg::*;

    localparam int NCPU = 8;
    localparam int NTHR = 1024;
    localparam int TIW  = $clog2(NTHR);

    logic [9:0]  clone_id;
    logic        cpu_has_thr[NCPU];
    logic [15:0] cpu_thr[NCPU];
    logic [3:0]  cpu_st[NCPU];
    logic [3:0]  thr_st[NTHR];
    logic [9:0]  thr_sc[NTHR];
    logic        thr_par_ok[NTHR];
    logic [15:0] thr_par[NTHR];

    out_pkt_t expected_q[$];

    function automatic logic [9:0] syscall_of(logic [15:0] t);
        return (t < NTHR) ? thr_sc[t[TIW-1:0]] : 10'd0;
    endfunction

    function automatic out_pkt_t apply_event(in_pkt_t e);
        out_pkt_t    r;
        logic        has_cur;
        logic [15:0] cur;
        logic        cur_ok;
        logic        touched;
        logic        oor;
        logic        rep_ok;
        logic [15:0] rep;
        logic        cpu_wr;
        logic [3:0]  new_cpu;
        logic [3:0]  s;
        logic        nsys;
        logic [9:0]  ps;
        logic [TIW-1:0] ti;
        logic [TIW-1:0] oi;
        has_cur = cpu_has_thr[e.cpu_id];
        cur = has_cur ? cpu_thr[e.cpu_id] : 16'd0;
        cur_ok = has_cur && (cur < NTHR);
        touched = 1'b0;
        oor = 1'b0;
        rep_ok = has_cur;
        rep = cur;
        cpu_wr = 1'b0;
        new_cpu = ST_UNSET;
        ti = e.thread_id[TIW-1:0];
        oi = e.other_thread_id[TIW-1:0];
        if ((e.req_type <= REQ_SOFTIRQ_EXIT || e.req_type == REQ_SYS_ENTRY) && has_cur
            && !cur_ok)
            oor = 1'b1;
        case (e.req_type) inside
            REQ_SYS_EXIT:
            begin
                if (cur_ok)
                begin
                    thr_sc[cur[TIW-1:0]] = 10'd0;
                    thr_st[cur[TIW-1:0]] = ST_USER;
                    touched = 1'b1;
                end
                cpu_wr = 1'b1;
                new_cpu = ST_USER;
            end
            REQ_IRQ_ENTRY, REQ_SOFTIRQ_ENTRY:
            begin
                if (cur_ok)
                begin
                    thr_st[cur[TIW-1:0]] = ST_INTERRUPTED;
                    touched = 1'b1;
                end
                cpu_wr = 1'b1;
                new_cpu = (e.req_type == REQ_IRQ_ENTRY) ? ST_IRQ : ST_SOFTIRQ;
            end
            REQ_IRQ_EXIT, REQ_SOFTIRQ_EXIT:
            begin
                if (has_cur)
                begin
                    s = (syscall_of(cur) != 0) ? ST_SYSCALL : ST_USER;
                    if (cur_ok)
                    begin
                        thr_st[cur[TIW-1:0]] = s;
                        touched = 1'b1;
                    end
                    cpu_wr = 1'b1;
                    new_cpu = s;
                end
                if (!has_cur || cur == 0)
                begin
                    cpu_wr = 1'b1;
                    new_cpu = ST_IDLE;
                end
            end
            REQ_SWITCH:
            begin
                if (e.thread_id < NTHR)
                begin
                    thr_st[ti] = e.prev_runnable ? ST_WAIT_CPU : ST_BLOCKED;
                    touched = 1'b1;
                end
                else
                    oor = 1'b1;
                nsys = syscall_of(e.other_thread_id) != 0;
                if (e.other_thread_id < NTHR)
                begin
                    thr_st[oi] = nsys ? ST_SYSCALL : ST_USER;
                    touched = 1'b1;
                end
                else
                    oor = 1'b1;
                cpu_has_thr[e.cpu_id] = 1'b1;
                cpu_thr[e.cpu_id] = e.other_thread_id;
                cpu_wr = 1'b1;
                new_cpu = (e.other_thread_id != 0) ? (nsys ? ST_SYSCALL : ST_USER) : ST_IDLE;
                rep_ok = 1'b1;
                rep = e.other_thread_id;
            end
            REQ_FORK:
            begin
                ps = syscall_of(e.other_thread_id);
                if (e.other_thread_id >= NTHR)
                    oor = 1'b1;
                if (e.thread_id < NTHR)
                begin
                    thr_par_ok[ti] = 1'b1;
                    thr_par[ti] = e.other_thread_id;
                    thr_st[ti] = ST_WAIT_CPU;
                    thr_sc[ti] = (ps != 0) ? ps : clone_id;
                    touched = 1'b1;
                end
                else
                    oor = 1'b1;
                rep_ok = 1'b1;
                rep = e.thread_id;
            end
            REQ_FREE, REQ_STATEDUMP, REQ_WAKEUP:
            begin
                rep_ok = 1'b1;
                rep = e.thread_id;
                if (e.thread_id >= NTHR)
                    oor = 1'b1;
                else if (e.req_type == REQ_FREE)
                begin
                    thr_st[ti] = ST_UNSET;
                    thr_sc[ti] = 10'd0;
                    thr_par_ok[ti] = 1'b0;
                    thr_par[ti] = 16'd0;
                    touched = 1'b1;
                end
                else if (e.req_type == REQ_STATEDUMP)
                begin
                    if (!thr_par_ok[ti])
                    begin
                        thr_par_ok[ti] = 1'b1;
                        thr_par[ti] = e.other_thread_id;
                        touched = 1'b1;
                    end
                    if (thr_st[ti] == ST_UNSET)
                    begin
                        thr_st[ti] = (e.dump_status == DUMP_WAIT_CPU) ? ST_WAIT_CPU :
                                     (e.dump_status == DUMP_BLOCKED) ? ST_BLOCKED : ST_UNKNOWN;
                        touched = 1'b1;
                    end
                end
                else if (thr_st[ti] != ST_USER && thr_st[ti] != ST_SYSCALL)
                begin
                    thr_st[ti] = ST_WAIT_CPU;
                    touched = 1'b1;
                end
            end
            REQ_SYS_ENTRY:
            begin
                if (cur_ok)
                begin
                    thr_sc[cur[TIW-1:0]] = e.syscall_id;
                    thr_st[cur[TIW-1:0]] = ST_SYSCALL;
                    touched = 1'b1;
                end
                cpu_wr = 1'b1;
                new_cpu = ST_SYSCALL;
            end
            default:
            begin
            end
        endcase
        if (cpu_wr)
            cpu_st[e.cpu_id] = new_cpu;
        r.cpu_status = cpu_st[e.cpu_id];
        r.thread_status = (rep_ok && rep < NTHR) ? thr_st[rep[TIW-1:0]] : ST_UNSET;
        r.thread_touched = touched;
        r.thread_out = rep_ok ? rep : 16'd0;
        r.tid_out_of_range = oor;
        return r;
    endfunction

    task automatic report(string what, int got, int want);
        $display("%t: %s got %0d, expected %0d", $realtime, what, got, want);
        errors++;
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        out_pkt_t want;
        if (!rst_n)
        begin
            clone_id = 10'd1;
            for (int i = 0; i < NCPU; i++)
            begin
                cpu_has_thr[i] = 1'b0;
                cpu_thr[i] = 16'd0;
                cpu_st[i] = ST_UNSET;
            end
            for (int i = 0; i < NTHR; i++)
            begin
                thr_st[i] = ST_UNSET;
                thr_sc[i] = 10'd0;
                thr_par_ok[i] = 1'b0;
                thr_par[i] = 16'd0;
            end
            expected_q.delete();
            errors = 0;
            pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
            begin
                if (expected_q.size() == 0)
                    report("transfer with nothing expected, thread_out", out_data.thread_out, -1);
                else
                begin
                    want = expected_q.pop_front();
                    if (out_data.cpu_status !== want.cpu_status)
                        report("cpu_status", out_data.cpu_status, want.cpu_status);
                    if (out_data.thread_status !== want.thread_status)
                        report("thread_status", out_data.thread_status, want.thread_status);
                    if (out_data.thread_touched !== want.thread_touched)
                        report("thread_touched", out_data.thread_touched, want.thread_touched);
                    if (out_data.thread_out !== want.thread_out)
                        report("thread_out", out_data.thread_out, want.thread_out);
                    if (out_data.tid_out_of_range !== want.tid_out_of_range)
                        report("tid_out_of_range", out_data.tid_out_of_range,
                               want.tid_out_of_range);
                end
            end
            if (in_valid && !in_stall)
                expected_q.push_back(apply_event(in_data));
            if (cfg_we)
                clone_id = cfg_data;
            pending <= expected_q.size();
        end
    end

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps

module tb_top;
    import ttcpu_pkg::*;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    in_pkt_t    in_data;
    logic       out_valid;
    logic       out_stall;
    out_pkt_t   out_data;
    logic       cfg_we;
    logic [9:0] cfg_data;
    int         errors;
    int         pending;
    int         send_idle_pct;
    int         recv_stall_pct;
    int         sent;
    int         cfg_writes;

    trace_thread_cpu_state_tracker_unit dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data)
    );

    tb_checker u_checker (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_data (out_data),
        .cfg_we   (cfg_we),
        .cfg_data (cfg_data),
        .errors   (errors),
        .pending  (pending)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    always @(posedge clk)
        out_stall <= ($urandom_range(99) < recv_stall_pct);

    initial
    begin
        #5ms;
        $display("Timeout waiting for transfers");
        $display("Mismatches found");
        $finish;
    end

    task automatic send_event(in_pkt_t e);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= e;
        do
            @(posedge clk);
        while (in_stall);
        sent++;
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic write_clone_id(logic [9:0] v);
        drain();
        repeat (8) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_writes++;
    endtask

    function automatic in_pkt_t make_event(logic [3:0] kind, logic [2:0] cpu,
                                           logic [15:0] tid, logic [15:0] oth);
        in_pkt_t e;
        e.req_type = kind;
        e.cpu_id = cpu;
        e.thread_id = tid;
        e.other_thread_id = oth;
        e.prev_runnable = 1'($urandom_range(1));
        e.dump_status = 8'($urandom_range(255));
        e.irq_number = 8'($urandom_range(255));
        e.softirq_vector = 4'($urandom_range(15));
        e.syscall_id = 10'($urandom_range(1023, 1));
        return e;
    endfunction

    function automatic logic [15:0] pick_tid();
        int r;
        r = $urandom_range(99);
        if (r < 80)
            return 16'($urandom_range(31));
        else if (r < 90)
            return 16'($urandom_range(1023));
        return 16'($urandom_range(65535));
    endfunction

    function automatic in_pkt_t random_event();
        logic [3:0] kind;
        int r;
        r = $urandom_range(99);
        if (r < 2)
            kind = 4'($urandom_range(15, 12));
        else if (r < 20)
            kind = REQ_SWITCH;
        else
            kind = 4'($urandom_range(11));
        return make_event(kind, 3'($urandom_range(7)), pick_tid(), pick_tid());
    endfunction

    task automatic run_phase(int idle_pct, int stall_pct, int count, bit pause_mid);
        send_idle_pct = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
        begin
            if (pause_mid && i == count / 2)
                drain();
            send_event(random_event());
        end
    endtask

    initial
    begin
        in_pkt_t e;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_data = '0;
        out_stall = 1'b0;
        cfg_we = 1'b0;
        cfg_data = 10'd0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        sent = 0;
        cfg_writes = 0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_clone_id(10'd1);
        send_event(make_event(REQ_SYS_ENTRY, 3'd0, 16'd0, 16'd0));
        send_event(make_event(REQ_IRQ_EXIT, 3'd0, 16'd0, 16'd0));
        send_event(make_event(REQ_SWITCH, 3'd1, 16'd3, 16'd0));
        send_event(make_event(REQ_IRQ_EXIT, 3'd1, 16'd0, 16'd0));
        send_event(make_event(REQ_SWITCH, 3'd0, 16'hFFFF, 16'd5));
        e = make_event(REQ_SYS_ENTRY, 3'd0, 16'd0, 16'd0);
        e.syscall_id = 10'd1023;
        send_event(e);
        e = make_event(REQ_IRQ_ENTRY, 3'd0, 16'd0, 16'd0);
        e.irq_number = 8'd255;
        send_event(e);
        e = make_event(REQ_IRQ_EXIT, 3'd0, 16'd0, 16'd0);
        e.irq_number = 8'd0;
        send_event(e);
        e = make_event(REQ_SOFTIRQ_RAISE, 3'd0, 16'd0, 16'd0);
        e.softirq_vector = 4'd15;
        send_event(e);
        send_event(make_event(REQ_SOFTIRQ_ENTRY, 3'd0, 16'd0, 16'd0));
        send_event(make_event(REQ_SOFTIRQ_EXIT, 3'd0, 16'd0, 16'd0));
        send_event(make_event(REQ_SYS_EXIT, 3'd0, 16'd0, 16'd0));
        send_event(make_event(REQ_FORK, 3'd2, 16'd6, 16'd5));
        send_event(make_event(REQ_FORK, 3'd2, 16'd7, 16'd9));
        send_event(make_event(REQ_FORK, 3'd2, 16'd2000, 16'hFFFF));
        e = make_event(REQ_STATEDUMP, 3'd3, 16'd10, 16'd1);
        e.dump_status = DUMP_WAIT_CPU;
        send_event(e);
        e = make_event(REQ_STATEDUMP, 3'd3, 16'd11, 16'd1);
        e.dump_status = DUMP_BLOCKED;
        send_event(e);
        e = make_event(REQ_STATEDUMP, 3'd3, 16'd1023, 16'd1);
        e.dump_status = 8'd255;
        send_event(e);
        send_event(make_event(REQ_WAKEUP, 3'd4, 16'd11, 16'd0));
        send_event(make_event(REQ_FREE, 3'd4, 16'd6, 16'd0));
        send_event(make_event(REQ_SWITCH, 3'd7, 16'd4, 16'd4000));
        e = make_event(REQ_SYS_ENTRY, 3'd7, 16'd0, 16'd0);
        e.syscall_id = 10'd0;
        send_event(e);
        send_event(make_event(REQ_IRQ_EXIT, 3'd7, 16'd0, 16'd0));
        send_event(make_event(4'd12, 3'd0, 16'd0, 16'd0));
        send_event(make_event(4'd15, 3'd7, 16'hFFFF, 16'hFFFF));

        write_clone_id(10'd1023);
        run_phase(36, 79, 560, 1'b1);
        write_clone_id(10'd1);
        run_phase(79, 36, 560, 1'b0);
        write_clone_id(10'($urandom_range(1022, 2)));
        run_phase(0, 0, 560, 1'b0);

        drain();
        repeat (20) @(posedge clk);
        $display("Covered %0d events of every kind over three handshake mixes", sent);
        $display("with %0d clone syscall id settings, including 1 and 1023", cfg_writes);
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
